// File: rtl/hlo_pkg.sv
// Shared types, sizes, opcodes, register indexes and the log2 fraction table
// of the histogram log-odds classifier. Depends on nothing.
`default_nettype none
package hlo_pkg;
  localparam int CELLS = 256;
  localparam int CELL_W = $clog2(CELLS);
  localparam int MAX_FEATURES = 16;
  localparam int FEAT_W = $clog2(MAX_FEATURES);
  localparam int MAX_CLASSES = 8;
  localparam int CLS_W = $clog2(MAX_CLASSES);
  localparam int CNT_W = 24;
  localparam int ROW_W = (MAX_CLASSES + 1) * CNT_W;
  localparam int ADDR_W = FEAT_W + CELL_W;
  localparam int ROWS = MAX_FEATURES * CELLS;
  localparam int LOG_W = 40;
  localparam int LOGQ_W = 14;
  localparam int LN2_Q16 = 45426;
  localparam int PADDR_W = 4;

  localparam logic [1:0] OP_RESTART   = 2'd0;
  localparam logic [1:0] OP_CALIBRATE = 2'd1;
  localparam logic [1:0] OP_TRAIN     = 2'd2;
  localparam logic [1:0] OP_CLASSIFY  = 2'd3;

  localparam logic [1:0] REG_CLASS_COUNT   = 2'd0;
  localparam logic [1:0] REG_FEATURE_COUNT = 2'd1;
  localparam logic [1:0] REG_SMOOTHING     = 2'd2;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic  we;
    addr_t addr;
    row_t  data;
  } mem_wr_t;

  localparam logic [7:0] LG_FRAC [64] = '{
    8'd0, 8'd6, 8'd11, 8'd17, 8'd22, 8'd28, 8'd33, 8'd38,
    8'd44, 8'd49, 8'd54, 8'd59, 8'd63, 8'd68, 8'd73, 8'd78,
    8'd82, 8'd87, 8'd92, 8'd96, 8'd100, 8'd105, 8'd109, 8'd113,
    8'd118, 8'd122, 8'd126, 8'd130, 8'd134, 8'd138, 8'd142, 8'd146,
    8'd150, 8'd154, 8'd157, 8'd161, 8'd165, 8'd169, 8'd172, 8'd176,
    8'd179, 8'd183, 8'd186, 8'd190, 8'd193, 8'd197, 8'd200, 8'd203,
    8'd207, 8'd210, 8'd213, 8'd216, 8'd220, 8'd223, 8'd226, 8'd229,
    8'd232, 8'd235, 8'd238, 8'd241, 8'd244, 8'd247, 8'd250, 8'd253
  };
endpackage
`default_nettype wire

// File: rtl/histogram_log_odds_online_classifier_core.sv
// Histogram log-odds classifier: sequencer, ranges, priors, accumulators.
// Calibrate or ignored item: handled in the idle state. Train in range: divider, then row read and update.
// Classify: two log2 passes per class for the cell row, and on
// the last feature two more per class for the prior term and the result, plus stalls.
// Reset and restart clear 4096 cell rows, one per cycle, while no item is taken.
// Depends on hlo_pkg, hlo_log2, hlo_cell_div, hlo_cell_mem.
`default_nettype none
module histogram_log_odds_online_classifier_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [3:0]                  feature_index,
  input  logic signed [31:0]          feature_value,
  input  logic signed [3:0]           class_label,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  class_index,
  output logic signed [23:0]          response,
  output logic                        last_class,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hlo_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import hlo_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_DIV   = 14'b00000000000100,
    S_RD    = 14'b00000000001000,
    S_RDW   = 14'b00000000010000,
    S_LCG   = 14'b00000000100000,
    S_LCW   = 14'b00000001000000,
    S_LDG   = 14'b00000010000000,
    S_LDW   = 14'b00000100000000,
    S_MUL   = 14'b00001000000000,
    S_RND   = 14'b00010000000000,
    S_ACC   = 14'b00100000000000,
    S_SCL   = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [3:0] class_count;
  logic [4:0] feature_count;
  logic [7:0] smoothing;
  logic [3:0] k_eff;
  logic [4:0] f_eff;

  logic signed [31:0] range_low [MAX_FEATURES];
  logic signed [31:0] range_high [MAX_FEATURES];
  logic [31:0]        prior_c [MAX_CLASSES];
  logic [39:0]        prior_total;
  logic signed [31:0] acc [MAX_CLASSES];

  logic [FEAT_W-1:0]  fi_r;
  logic [CELL_W-1:0]  cell_r;
  logic [CLS_W-1:0]   cls;
  logic [CLS_W-1:0]   lbl_r;
  logic               lbl_ok_r;
  logic               last_r;
  logic               train_r;
  logic               prior_r;
  logic [LOGQ_W-1:0]  lc;
  logic [LOGQ_W-1:0]  ld;
  logic signed [32:0] p_r;
  logic signed [17:0] lnv;
  logic signed [23:0] r_r;
  addr_t              clr_addr;

  logic               in_accept;
  logic               fi_ok;
  logic               last_in;
  logic               lbl_ok_in;
  logic               hit;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic               cls_last;

  logic               div_start;
  logic               div_done;
  logic [CELL_W-1:0]  div_q;
  logic [32:0]        div_off;
  logic [32:0]        div_span;

  logic               log_start;
  logic [LOG_W-1:0]   log_x;
  logic               log_done;
  logic [LOGQ_W-1:0]  log_y;
  logic [LOG_W-1:0]   c_sel;
  logic [LOG_W-1:0]   t_sel;
  logic [LOG_W-1:0]   d_sel;

  mem_wr_t            mem_wr;
  logic               mem_re;
  row_t               mem_rdata;
  row_t               row_upd;
  row_t               clr_row;
  cnt_t               st;

  logic signed [14:0] diff;
  logic signed [17:0] ln2_c;
  logic signed [32:0] p_full;
  logic [32:0]        p_abs;
  logic [16:0]        p_q;
  logic signed [17:0] ln_rnd;
  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_sat;
  logic signed [23:0] scaled;
  logic signed [33:0] r_full;
  logic signed [23:0] r_sat;

  assign k_eff = (class_count == 4'd0) ? 4'd1 :
                 (class_count > 4'(MAX_CLASSES)) ? 4'(MAX_CLASSES) : class_count;
  assign f_eff = (feature_count == 5'd0) ? 5'd1 :
                 (feature_count > 5'(MAX_FEATURES)) ? 5'(MAX_FEATURES) : feature_count;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_CLASS_COUNT:   prdata = {28'd0, class_count};
      REG_FEATURE_COUNT: prdata = {27'd0, feature_count};
      REG_SMOOTHING:     prdata = {24'd0, smoothing};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count   <= 4'd2;
      feature_count <= 5'd16;
      smoothing     <= 8'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_CLASS_COUNT:   class_count <= pwdata[3:0];
        REG_FEATURE_COUNT: feature_count <= pwdata[4:0];
        REG_SMOOTHING:     smoothing <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign fi_ok     = {1'b0, feature_index} < f_eff;
  assign last_in   = {1'b0, feature_index} == (f_eff - 5'd1);
  assign lbl_ok_in = !class_label[3] && ({1'b0, class_label[2:0]} < k_eff);
  assign lo        = range_low[feature_index];
  assign hi        = range_high[feature_index];
  assign hit       = (hi > lo) && (feature_value >= lo) && (feature_value < hi);
  assign cls_last  = {1'b0, cls} == (k_eff - 4'd1);

  assign div_off   = {feature_value[31], feature_value} - {lo[31], lo};
  assign div_span  = {hi[31], hi} - {lo[31], lo};
  assign div_start = in_accept && fi_ok && hit &&
                     ((opcode == OP_TRAIN) || (opcode == OP_CLASSIFY));

  hlo_cell_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .off   (div_off),
    .span  (div_span),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    if (prior_r) begin
      c_sel = {8'd0, prior_c[cls]};
      t_sel = prior_total;
    end else begin
      c_sel = {16'd0, mem_rdata[cls*CNT_W +: CNT_W]};
      t_sel = {16'd0, mem_rdata[MAX_CLASSES*CNT_W +: CNT_W]};
    end
    d_sel = (t_sel > c_sel) ? (t_sel - c_sel) : LOG_W'(1);
  end

  assign log_start = (state == S_LCG) || (state == S_LDG);
  assign log_x     = (state == S_LCG) ? c_sel : d_sel;

  hlo_log2 u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .x     (log_x),
    .done  (log_done),
    .y     (log_y)
  );

  assign st = CNT_W'(smoothing) * CNT_W'(5'({1'b0, k_eff}) + 5'd1);

  always_comb begin
    row_upd = mem_rdata;
    clr_row = '0;
    for (int i = 0; i < MAX_CLASSES; i++) begin
      clr_row[i*CNT_W +: CNT_W] = CNT_W'(smoothing);
      if (lbl_ok_r && (lbl_r == CLS_W'(i)) && (mem_rdata[i*CNT_W +: CNT_W] != '1)) begin
        row_upd[i*CNT_W +: CNT_W] = mem_rdata[i*CNT_W +: CNT_W] + CNT_W'(1);
      end
    end
    clr_row[MAX_CLASSES*CNT_W +: CNT_W] = st;
    if (mem_rdata[MAX_CLASSES*CNT_W +: CNT_W] != '1) begin
      row_upd[MAX_CLASSES*CNT_W +: CNT_W] = mem_rdata[MAX_CLASSES*CNT_W +: CNT_W] + CNT_W'(1);
    end
  end

  always_comb begin
    mem_wr.we   = (state == S_CLEAR) || ((state == S_RDW) && train_r);
    mem_wr.addr = (state == S_CLEAR) ? clr_addr : {fi_r, cell_r};
    mem_wr.data = (state == S_CLEAR) ? clr_row : row_upd;
  end
  assign mem_re = (state == S_RD);

  hlo_cell_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .re    (mem_re),
    .raddr ({fi_r, cell_r}),
    .rdata (mem_rdata)
  );

  assign ln2_c = 18'sd45426;
  assign diff  = $signed({1'b0, lc}) - $signed({1'b0, ld});
  assign p_full = diff * ln2_c;

  always_comb begin
    p_abs  = p_r[32] ? 33'(-p_r) : p_r;
    p_q    = 17'((p_abs + 33'd32768) >> 16);
    ln_rnd = p_r[32] ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
    acc_sum = acc[cls] + lnv;
    if (acc_sum[32] != acc_sum[31]) begin
      acc_sat = acc_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      acc_sat = acc_sum[31:0];
    end
    scaled = lnv * $signed({1'b0, f_eff - 5'd1});
    r_full = acc[cls] - scaled;
    if (r_full > 34'sd8388607) begin
      r_sat = 24'sh7FFFFF;
    end else if (r_full < -34'sd8388608) begin
      r_sat = 24'sh800000;
    end else begin
      r_sat = r_full[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      prior_r   <= 1'b0;
      for (int i = 0; i < MAX_FEATURES; i++) begin
        range_low[i]  <= 32'sh7FFFFFFF;
        range_high[i] <= 32'sh80000000;
      end
      for (int i = 0; i < MAX_CLASSES; i++) begin
        prior_c[i] <= 32'(CELLS);
        acc[i]     <= '0;
      end
      prior_total <= 40'(CELLS * 3);
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(ROWS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            fi_r     <= feature_index;
            last_r   <= last_in;
            lbl_ok_r <= lbl_ok_in;
            lbl_r    <= class_label[2:0];
            train_r  <= (opcode == OP_TRAIN);
            if (opcode == OP_RESTART) begin
              for (int i = 0; i < MAX_FEATURES; i++) begin
                range_low[i]  <= 32'sh7FFFFFFF;
                range_high[i] <= 32'sh80000000;
              end
              for (int i = 0; i < MAX_CLASSES; i++) begin
                prior_c[i] <= 32'(smoothing) * 32'(CELLS);
                acc[i]     <= '0;
              end
              prior_total <= 40'(st) << CELL_W;
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else if (fi_ok) begin
              if (opcode == OP_CALIBRATE) begin
                if (feature_value < lo) range_low[feature_index] <= feature_value;
                if (feature_value > hi) range_high[feature_index] <= feature_value;
              end else begin
                if ((opcode == OP_TRAIN) && last_in) begin
                  if (lbl_ok_in && (prior_c[class_label[2:0]] != '1)) begin
                    prior_c[class_label[2:0]] <= prior_c[class_label[2:0]] + 32'd1;
                  end
                  if (prior_total != '1) prior_total <= prior_total + 40'd1;
                end
                if (hit) begin
                  state <= S_DIV;
                end else if ((opcode == OP_CLASSIFY) && last_in) begin
                  prior_r <= 1'b1;
                  cls     <= '0;
                  state   <= S_LCG;
                end
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            cell_r <= div_q;
            state  <= S_RD;
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          if (train_r) begin
            state <= S_IDLE;
          end else begin
            prior_r <= 1'b0;
            cls     <= '0;
            state   <= S_LCG;
          end
        end
        S_LCG: state <= S_LCW;
        S_LCW: begin
          if (log_done) begin
            lc    <= log_y;
            state <= S_LDG;
          end
        end
        S_LDG: state <= S_LDW;
        S_LDW: begin
          if (log_done) begin
            ld    <= log_y;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p_r   <= p_full;
          state <= S_RND;
        end
        S_RND: begin
          lnv   <= ln_rnd;
          state <= prior_r ? S_SCL : S_ACC;
        end
        S_ACC: begin
          acc[cls] <= acc_sat;
          if (cls_last) begin
            if (last_r) begin
              prior_r <= 1'b1;
              cls     <= '0;
              state   <= S_LCG;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            cls   <= cls + CLS_W'(1);
            state <= S_LCG;
          end
        end
        S_SCL: begin
          r_r   <= r_sat;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            class_index <= cls;
            response    <= r_r;
            last_class  <= cls_last;
            if (cls_last) begin
              for (int i = 0; i < MAX_CLASSES; i++) acc[i] <= '0;
              state <= S_IDLE;
            end else begin
              cls   <= cls + CLS_W'(1);
              state <= S_LCG;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_log_done: assert property (@(posedge clk) disable iff (rst)
    log_done |-> (state == S_LCW || state == S_LDW))
    else $error("log2 result outside a wait state");

  ap_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider result outside the divide state");

  ap_emit_cls: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ({1'b0, cls} < k_eff))
    else $error("result class beyond classes in use");

  ap_mem_we: assert property (@(posedge clk) disable iff (rst)
    mem_wr.we |-> (state == S_CLEAR || (state == S_RDW && train_r)))
    else $error("cell store written outside clear or train");
endmodule
`default_nettype wire

// File: rtl/hlo_log2.sv
// Multi-cycle log2 unit: byte-wise normalize, then table lookup, Q6.8 result.
// Depends on hlo_pkg.
`default_nettype none
module hlo_log2 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hlo_pkg::LOG_W-1:0]  x,
  output logic                       done,
  output logic [hlo_pkg::LOGQ_W-1:0] y
);
  import hlo_pkg::*;

  logic             busy;
  logic [LOG_W-1:0] sh;
  logic [5:0]       e;
  logic [2:0]       pos;
  logic [LOG_W-1:0] norm;
  logic [5:0]       efin;

  always_comb begin
    pos = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (sh[LOG_W-8+i]) pos = 3'(i);
    end
    norm = sh << (~pos);
    efin = e - {3'b000, ~pos};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        sh   <= (x == '0) ? LOG_W'(1) : x;
        e    <= 6'(LOG_W - 1);
      end else if (busy) begin
        if (sh[LOG_W-1 -: 8] == 8'd0) begin
          sh <= sh << 8;
          e  <= e - 6'd8;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          y    <= {efin, LG_FRAC[norm[LOG_W-2 -: 6]]};
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/hlo_cell_div.sv
// Restoring divider for the cell number, one quotient bit per cycle.
// Depends on hlo_pkg.
`default_nettype none
module hlo_cell_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [32:0]                off,
  input  logic [32:0]                span,
  output logic                       done,
  output logic [hlo_pkg::CELL_W-1:0] q
);
  import hlo_pkg::*;
  localparam int CW = $clog2(CELL_W + 1);

  logic          busy;
  logic [33:0]   rem;
  logic [32:0]   dv;
  logic [CW-1:0] cnt;
  logic [33:0]   r2;
  logic          ge;

  assign r2 = {rem[32:0], 1'b0};
  assign ge = r2 >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= {1'b0, off};
        dv   <= span;
        cnt  <= CW'(CELL_W);
      end else if (busy) begin
        rem <= ge ? (r2 - {1'b0, dv}) : r2;
        q   <= CELL_W'({q, ge});
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/hlo_cell_mem.sv
// Cell store: one row per feature cell with all class counts and the total.
// Depends on hlo_pkg.
`default_nettype none
module hlo_cell_mem (
  input  logic             clk,
  input  hlo_pkg::mem_wr_t wr,
  input  logic             re,
  input  hlo_pkg::addr_t   raddr,
  output hlo_pkg::row_t    rdata
);
  import hlo_pkg::*;

  row_t mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
